@@ src/hlep_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlep_pkg
// Shared types, character codes and decode helpers for the hex line parser.
// ----------------------------------------------------------------------------
package hlep_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned LEN_W   = 7;

	// control characters
	localparam logic [CHAR_W-1:0] CH_NUL  = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS   = 8'h08;
	localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_ESC  = 8'h1B;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_X_LC = 8'h78;
	localparam logic [CHAR_W-1:0] CH_X_UC = 8'h58;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_INVALID  = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	// one result word
	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [LEN_W-1:0]          length;
		status_t                   status;
	} result_t;

	// bit 4 set when the character is a hex digit, bits 3:0 its value
	function automatic logic [4:0] hex_digit(input logic [CHAR_W-1:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h41 + 8'd10)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h61 + 8'd10)};
		end
		return r;
	endfunction

	function automatic logic is_x(input logic [CHAR_W-1:0] c);
		return (c == CH_X_LC) || (c == CH_X_UC);
	endfunction

	function automatic logic is_term(input logic [CHAR_W-1:0] c);
		return (c == CH_NUL) || (c == CH_LF) || (c == CH_CR) || (c == CH_ESC);
	endfunction

endpackage

@@ src/hlep_hist_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlep_hist_mem
// Character history store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module hlep_hist_mem #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = 6
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [hlep_pkg::CHAR_W-1:0] wdata,
	input  logic [AW-1:0]               raddr,
	output logic [hlep_pkg::CHAR_W-1:0] rdata
);

	logic [hlep_pkg::CHAR_W-1:0] mem_q [DEPTH];
	logic [hlep_pkg::CHAR_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ src/hlep_out_skid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlep_out_skid
// Output register with one skid entry; upstream ready is fully registered.
// ----------------------------------------------------------------------------
module hlep_out_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  hlep_pkg::result_t push_data,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output hlep_pkg::result_t out_data
);

	logic              ov_q;
	logic              sv_q;
	hlep_pkg::result_t od_q;
	hlep_pkg::result_t sd_q;
	logic              pop;

	assign pop = ov_q && out_ready;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (pop) begin
				sv_q <= 1'b0;
			end
		end else if (push && ov_q && !pop) begin
			sv_q <= 1'b1;
		end else if (push) begin
			ov_q <= 1'b1;
		end else if (pop) begin
			ov_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (pop) begin
				od_q <= sd_q;
			end
		end else if (push && ov_q && !pop) begin
			sd_q <= push_data;
		end else if (push) begin
			od_q <= push_data;
		end
	end

	assign space     = !sv_q;
	assign out_valid = ov_q;
	assign out_data  = od_q;

endmodule

@@ src/hex_line_editor_parser_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hex_line_editor_parser_unit
// Hex line parser with prefix handling, backspace editing and a history stack.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle unless the output buffer is full; the top
//   of stack sits in a register and the entry below it is read ahead from the
//   history memory every cycle. Results are registered in the output buffer.
// Reset: line state and output buffer clear; the history memory is not cleared.
// ----------------------------------------------------------------------------
module hex_line_editor_parser_unit #(
	parameter int unsigned HISTORY_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [hlep_pkg::CHAR_W-1:0]  character,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [hlep_pkg::VALUE_W-1:0] value,
	output logic [hlep_pkg::LEN_W-1:0]   length,
	output logic [1:0]                   status
);

	localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

	typedef enum logic [1:0] {
		PFX_NONE = 2'd0,
		PFX_ZERO = 2'd1,
		PFX_0X   = 2'd2,
		PFX_X    = 2'd3
	} prefix_t;

	logic signed [hlep_pkg::VALUE_W-1:0] acc_q, acc_d;
	logic [CW-1:0]                       cnt_q, cnt_d;
	prefix_t                             pfx_q, pfx_d;
	logic [hlep_pkg::CHAR_W-1:0]         top_q, top_d;

	logic                        in_fire;
	logic [4:0]                  dig;
	logic [4:0]                  top_dig;
	logic                        take;
	prefix_t                     new_pfx;
	logic                        use_digit;
	logic [hlep_pkg::VALUE_W-1:0] div_sum;
	logic                        res_valid;
	hlep_pkg::result_t           res;
	hlep_pkg::result_t           out_data;
	logic                        space;
	logic                        mem_we;
	logic [CW-1:0]               rd_cnt;
	logic [hlep_pkg::CHAR_W-1:0] below_top;

	assign in_ready = space;
	assign in_fire  = in_valid && in_ready;
	assign dig      = hlep_pkg::hex_digit(character);
	assign top_dig  = hlep_pkg::hex_digit(top_q);
	// bias negatives by 15 so the arithmetic shift truncates toward zero
	assign div_sum  = acc_q + {{(hlep_pkg::VALUE_W-4){1'b0}}, {4{acc_q[hlep_pkg::VALUE_W-1]}}};

	// classify a non-control character
	always_comb begin
		take      = 1'b0;
		new_pfx   = pfx_q;
		use_digit = dig[4];
		if (character == hlep_pkg::CH_ZERO && cnt_q == '0) begin
			take      = 1'b1;
			new_pfx   = PFX_ZERO;
			use_digit = 1'b0;
		end else if (hlep_pkg::is_x(character) && cnt_q == '0) begin
			take    = 1'b1;
			new_pfx = PFX_X;
		end else if (hlep_pkg::is_x(character) && pfx_q == PFX_ZERO
				&& cnt_q == CW'(1)) begin
			take    = 1'b1;
			new_pfx = PFX_0X;
		end else if (dig[4] && pfx_q != PFX_ZERO) begin
			take = 1'b1;
		end
	end

	// next line state and result
	always_comb begin
		acc_d     = acc_q;
		cnt_d     = cnt_q;
		pfx_d     = pfx_q;
		top_d     = top_q;
		mem_we    = 1'b0;
		res_valid = 1'b0;
		res       = '{value: acc_q, length: '0, status: hlep_pkg::ST_OK};
		if (in_fire) begin
			if (hlep_pkg::is_term(character)) begin
				res_valid = 1'b1;
				res.length = hlep_pkg::LEN_W'(cnt_q);
			end else if (character == hlep_pkg::CH_BS) begin
				if (cnt_q != '0) begin
					// undo the popped character
					if (top_q == hlep_pkg::CH_ZERO && cnt_q == CW'(1)) begin
						pfx_d = PFX_NONE;
					end else if (hlep_pkg::is_x(top_q) && cnt_q == CW'(1)) begin
						pfx_d = PFX_NONE;
					end else if (hlep_pkg::is_x(top_q) && pfx_q == PFX_0X
							&& cnt_q == CW'(2)) begin
						pfx_d = PFX_ZERO;
					end else if (top_dig[4]) begin
						acc_d = {{4{div_sum[hlep_pkg::VALUE_W-1]}},
							div_sum[hlep_pkg::VALUE_W-1:4]};
					end
					cnt_d = cnt_q - CW'(1);
					top_d = below_top;
				end
			end else if (!take) begin
				res_valid  = 1'b1;
				res.status = hlep_pkg::ST_INVALID;
			end else if (cnt_q >= CW'(HISTORY_DEPTH)) begin
				res_valid  = 1'b1;
				res.status = hlep_pkg::ST_OVERFLOW;
			end else begin
				if (use_digit) begin
					acc_d = {acc_q[hlep_pkg::VALUE_W-5:0], dig[3:0]};
				end
				pfx_d  = new_pfx;
				top_d  = character;
				cnt_d  = cnt_q + CW'(1);
				mem_we = 1'b1;
			end
			if (res_valid) begin
				acc_d = '0;
				cnt_d = '0;
				pfx_d = PFX_NONE;
			end
		end
	end

	// read ahead the entry below the next top of stack
	assign rd_cnt = (cnt_d >= CW'(2)) ? (cnt_d - CW'(2)) : '0;

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			pfx_q <= PFX_NONE;
			top_q <= '0;
		end else begin
			acc_q <= acc_d;
			cnt_q <= cnt_d;
			pfx_q <= pfx_d;
			top_q <= top_d;
		end
	end

	hlep_hist_mem #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (AW)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (character),
		.raddr (rd_cnt[AW-1:0]),
		.rdata (below_top)
	);

	hlep_out_skid u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.space     (space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign value  = out_data.value;
	assign length = out_data.length;
	assign status = out_data.status;

`ifndef NO_ASSERTIONS
	// stack never holds more than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(HISTORY_DEPTH))
		else $error("history count above depth");

	// a lone leading zero is always the only character held
	a_zero_alone: assert property (@(posedge clk) disable iff (!arst_n)
		pfx_q == PFX_ZERO |-> cnt_q == CW'(1))
		else $error("lone zero prefix with wrong count");

	// every result clears the line
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (cnt_q == '0 && acc_q == '0 && pfx_q == PFX_NONE))
		else $error("line not cleared after result");

	// input stalls only while a result is pending on the output
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the hex line parser. Characters go in over a
// valid/ready channel and every result word is checked field by field
// against a cycle-free line editor model kept in a small scoreboard class.
// A short directed run covers the edge cases. Random lines follow in four
// idle phases: none, sender, receiver, both. There are two long receiver
// hold-offs and there are sender pauses until all results have drained.
// ----------------------------------------------------------------------------

// prefix tracking of the line model
typedef enum logic [1:0] {
	PFX_NONE = 2'd0,
	PFX_ZERO = 2'd1,
	PFX_HEX  = 2'd2,
	PFX_X    = 2'd3
} prefix_t;

// line model plus queue of result words still due
class hex_line_scoreboard #(int unsigned DEPTH = 64);
	logic [hlep_pkg::VALUE_W-1:0] acc        = '0;
	int unsigned                  held       = 0;
	prefix_t                      pfx        = PFX_NONE;
	logic [hlep_pkg::CHAR_W-1:0]  hist [DEPTH];
	hlep_pkg::result_t            due [$];
	int unsigned                  errors     = 0;
	int unsigned                  words_used = 0;
	int unsigned                  n_ok       = 0;
	int unsigned                  n_invalid  = 0;
	int unsigned                  n_overflow = 0;

	static function int digit_of(logic [hlep_pkg::CHAR_W-1:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		return -1;
	endfunction

	static function bit prefix_letter(logic [hlep_pkg::CHAR_W-1:0] c);
		return c == hlep_pkg::CH_X_LC || c == hlep_pkg::CH_X_UC;
	endfunction

	// divide by 16, truncating toward zero
	static function logic [hlep_pkg::VALUE_W-1:0] shift_out(
			logic [hlep_pkg::VALUE_W-1:0] a);
		logic [hlep_pkg::VALUE_W-1:0] mag;
		if (a[hlep_pkg::VALUE_W-1]) begin
			mag = (64'd0 - a) >> 4;
			return 64'd0 - mag;
		end
		return a >> 4;
	endfunction

	function int pending();
		return due.size();
	endfunction

	// queue a result word and start a fresh line
	function void finish_line(hlep_pkg::status_t st, logic [hlep_pkg::LEN_W-1:0] len);
		hlep_pkg::result_t r;
		r.value  = acc;
		r.length = len;
		r.status = st;
		due.push_back(r);
		acc  = '0;
		held = 0;
		pfx  = PFX_NONE;
	endfunction

	// one accepted character
	function void note_word(logic [hlep_pkg::CHAR_W-1:0] c);
		int                          d;
		logic [hlep_pkg::CHAR_W-1:0] top;
		prefix_t                     nxt;
		bit                          ok;
		d   = digit_of(c);
		nxt = pfx;
		ok  = 1'b0;
		if (c == hlep_pkg::CH_NUL || c == hlep_pkg::CH_LF || c == hlep_pkg::CH_CR
				|| c == hlep_pkg::CH_ESC) begin
			words_used++;
			finish_line(hlep_pkg::ST_OK, hlep_pkg::LEN_W'(held));
			return;
		end
		// backspace undoes the top of the history
		if (c == hlep_pkg::CH_BS) begin
			if (held == 0) return;
			words_used++;
			top = hist[held-1];
			if (top == hlep_pkg::CH_ZERO && held == 1) pfx = PFX_NONE;
			else if (prefix_letter(top) && held == 1) pfx = PFX_NONE;
			else if (prefix_letter(top) && pfx == PFX_HEX && held == 2) pfx = PFX_ZERO;
			else if (digit_of(top) >= 0) acc = shift_out(acc);
			held--;
			return;
		end
		words_used++;
		if (c == hlep_pkg::CH_ZERO && held == 0) begin
			ok  = 1'b1;
			nxt = PFX_ZERO;
			d   = -1;
		end else if (prefix_letter(c) && held == 0) begin
			ok  = 1'b1;
			nxt = PFX_X;
		end else if (prefix_letter(c) && pfx == PFX_ZERO && held == 1) begin
			ok  = 1'b1;
			nxt = PFX_HEX;
		end else if (d >= 0 && pfx != PFX_ZERO) begin
			ok = 1'b1;
		end
		if (!ok) begin
			finish_line(hlep_pkg::ST_INVALID, '0);
			return;
		end
		if (held >= DEPTH) begin
			finish_line(hlep_pkg::ST_OVERFLOW, '0);
			return;
		end
		if (d >= 0) acc = (acc << 4) + 64'(d);
		pfx        = nxt;
		hist[held] = c;
		held++;
	endfunction

	// compare one accepted result word with the oldest one due
	function void check_word(logic [hlep_pkg::VALUE_W-1:0] v,
			logic [hlep_pkg::LEN_W-1:0] len, logic [1:0] st);
		hlep_pkg::result_t e;
		if (due.size() == 0) begin
			errors++;
			$display("%0t: unexpected result value=%h length=%0d status=%0d",
				$time, v, len, st);
			return;
		end
		e = due.pop_front();
		if (v !== e.value) begin
			errors++;
			$display("%0t: value mismatch expected=%h actual=%h", $time, e.value, v);
		end
		if (len !== e.length) begin
			errors++;
			$display("%0t: length mismatch expected=%0d actual=%0d", $time, e.length, len);
		end
		if (st !== e.status) begin
			errors++;
			$display("%0t: status mismatch expected=%0d actual=%0d", $time, e.status, st);
		end
		case (st)
			hlep_pkg::ST_OK:      n_ok++;
			hlep_pkg::ST_INVALID: n_invalid++;
			default:              n_overflow++;
		endcase
	endfunction
endclass

module testbench;

	localparam int unsigned HDEPTH       = 64;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned LIMIT_CYCLES = 200000;

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                in_valid  = 1'b0;
	logic                                in_ready;
	logic [hlep_pkg::CHAR_W-1:0]         character = '0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic signed [hlep_pkg::VALUE_W-1:0] value;
	logic [hlep_pkg::LEN_W-1:0]          length;
	logic [1:0]                          status;

	hex_line_scoreboard #(HDEPTH) sb;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_reqs      = 0;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned cycle_count    = 0;

	// edge cases: empty lines, every prefix form, editing, bad characters
	logic [hlep_pkg::CHAR_W-1:0] directed_words [] = '{
		hlep_pkg::CH_BS, hlep_pkg::CH_NUL,
		hlep_pkg::CH_ZERO, hlep_pkg::CH_X_LC, "f", "F", hlep_pkg::CH_LF,
		hlep_pkg::CH_X_UC, "a", "9", hlep_pkg::CH_BS, "7", hlep_pkg::CH_CR,
		hlep_pkg::CH_ZERO, "5",
		hlep_pkg::CH_ZERO, hlep_pkg::CH_X_UC, hlep_pkg::CH_BS, hlep_pkg::CH_BS,
		"3", hlep_pkg::CH_ESC,
		"1", hlep_pkg::CH_X_LC,
		"G",
		hlep_pkg::CH_ZERO, hlep_pkg::CH_LF
	};

	hex_line_editor_parser_unit #(
		.HISTORY_DEPTH(HDEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.character(character),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.value    (value),
		.length   (length),
		.status   (status)
	);

	always #2 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("testbench failed");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_seen <= 0;
			hold_left <= 0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// handshakes are sampled mid-cycle, away from the driving edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_word(value, length, status);
			if (in_valid && in_ready) sb.note_word(character);
		end
	end

	function automatic logic [hlep_pkg::CHAR_W-1:0] hex_char(input int unsigned v);
		if (v < 10) return hlep_pkg::CH_ZERO + hlep_pkg::CHAR_W'(v);
		return ($urandom_range(0, 1) ? "a" : "A") + hlep_pkg::CHAR_W'(v - 10);
	endfunction

	// offer one word and hold it until taken
	task automatic send_word(input logic [hlep_pkg::CHAR_W-1:0] c);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		character <= c;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// sender pause until every result due has come back
	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// one line: mostly well formed, some noise, some broken
	task automatic send_random_line();
		int                          kind;
		int                          pfx_kind;
		int                          ndig;
		int                          bad_at;
		int                          nbs;
		bit                          negative;
		logic [hlep_pkg::CHAR_W-1:0] bad;
		kind = $urandom_range(0, 99);
		if (kind < 8) begin
			repeat ($urandom_range(1, 6))
				send_word(hlep_pkg::CHAR_W'($urandom_range(0, 255)));
			return;
		end
		negative = (kind >= 11 && kind < 25);
		pfx_kind = $urandom_range(0, 5);
		if (kind < 11) ndig = $urandom_range(60, 66);
		else if (negative) ndig = 16;
		else ndig = $urandom_range(0, 12);
		if (negative && pfx_kind == 5) pfx_kind = 0;
		bad_at = (kind >= 85) ? int'($urandom_range(0, ndig)) : -1;
		case (pfx_kind)
			1: begin
				send_word(hlep_pkg::CH_ZERO);
				send_word(hlep_pkg::CH_X_LC);
			end
			2: begin
				send_word(hlep_pkg::CH_ZERO);
				send_word(hlep_pkg::CH_X_UC);
			end
			3: send_word(hlep_pkg::CH_X_LC);
			4: send_word(hlep_pkg::CH_X_UC);
			5: send_word(hlep_pkg::CH_ZERO);
			default: ;
		endcase
		for (int i = 0; i <= ndig; i++) begin
			if (i == bad_at) begin
				case ($urandom_range(0, 2))
					0: bad = hlep_pkg::CH_X_LC;
					1: bad = hlep_pkg::CH_X_UC;
					default: bad = hlep_pkg::CHAR_W'($urandom_range(0, 255));
				endcase
				send_word(bad);
			end
			if (i == ndig) break;
			if (!negative && $urandom_range(0, 9) == 0)
				repeat ($urandom_range(1, 2)) send_word(hlep_pkg::CH_BS);
			if (negative && i == 0) send_word(hex_char($urandom_range(8, 15)));
			else send_word(hex_char($urandom_range(0, 15)));
		end
		// trailing edits: always on negative values, sometimes past empty
		nbs = 0;
		if (negative) nbs = $urandom_range(1, 4);
		else if ($urandom_range(0, 99) < 15) nbs = $urandom_range(1, ndig + 3);
		repeat (nbs) send_word(hlep_pkg::CH_BS);
		case ($urandom_range(0, 3))
			0: send_word(hlep_pkg::CH_NUL);
			1: send_word(hlep_pkg::CH_LF);
			2: send_word(hlep_pkg::CH_CR);
			default: send_word(hlep_pkg::CH_ESC);
		endcase
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i]) send_word(directed_words[i]);
		wait_for_results();

		// no idling, with a long receiver hold-off at the start
		hold_reqs <= hold_reqs + 1;
		while (sb.words_used < 380) send_random_line();

		// sender idle most cycles, then drain
		send_idle_pct = 77;
		while (sb.words_used < 740) send_random_line();
		wait_for_results();

		// receiver stalling most cycles
		send_idle_pct  = 0;
		recv_stall_pct = 77;
		while (sb.words_used < 1100) send_random_line();

		// light idling on both sides, one more hold-off
		send_idle_pct  = 15;
		recv_stall_pct = 15;
		hold_reqs <= hold_reqs + 1;
		while (sb.words_used < 1460) send_random_line();

		wait_for_results();
		repeat (10) @(posedge clk);

		$display("summary: %0d characters applied, %0d results (%0d ok, %0d invalid, %0d overflow)",
			sb.words_used, sb.n_ok + sb.n_invalid + sb.n_overflow,
			sb.n_ok, sb.n_invalid, sb.n_overflow);
		$display("summary: idle phases none/sender/receiver/both, two receiver hold-offs, %0d errors",
			sb.errors);
		if (sb.errors == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule
